/* design/assert_macros.svh */
// Assertion helpers used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* design/bthid_pkg.sv */
// ----------------------------------------------------------------------------
// bthid_pkg
// Types and codes for the button to HID report mapper.
// ----------------------------------------------------------------------------
package bthid_pkg;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_UNMOUNT = 2'd3
  } cmd_e;

  localparam logic [2:0] T_KEY   = 3'd1;
  localparam logic [2:0] T_MOUSE = 3'd2;
  localparam logic [2:0] T_AXIS  = 3'd3;
  localparam logic [2:0] T_PAD   = 3'd4;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_MOUSE = 2'd1;
  localparam logic [1:0] KIND_PAD   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  node;
    logic [2:0]  button;
    logic [18:0] action_a;
    logic [18:0] action_b;
    logic [18:0] action_c;
    logic [18:0] action_d;
    logic [15:0] first_delay;
    logic [15:0] repeat_delay;
    logic [31:0] now_ms;
    logic        host_ready;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        report_kind;
    logic [47:0]       key_slots;
    logic [7:0]        modifier_bits;
    logic [7:0]        mouse_button_bits;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic signed [7:0] delta_wheel;
    logic [31:0]       pad_button_bits;
    logic              last_report;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRESS_ACT,
    ST_REL_RD,
    ST_REL_ACT,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_ACT,
    ST_TICK_SUM,
    ST_EMIT_KEY,
    ST_EMIT_MOUSE,
    ST_EMIT_PAD
  } state_e;

endpackage

/* design/button_to_hid_report_mapper_core.sv */
// ----------------------------------------------------------------------------
// button_to_hid_report_mapper_core
// Maps button press and release events to keyboard, mouse and gamepad reports.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a transaction on in_i with start while busy is low. Press and
//   release update the report state; tick walks every entry, applies due
//   repeats and, if host_ready is set, emits up to three reports on out_o,
//   each marked by out_valid_o for one cycle. The receiver cannot stall.
//   Press holds busy while its actions pass, one per cycle, through the
//   shared action unit; release first reads the binding from the action
//   memory, then applies one action per cycle; unmount and a release of an
//   idle entry do not raise busy. A tick reads each entry and checks it; a
//   due entry then applies its actions one per cycle from the single read
//   port of the action memory and writes its next due time. Three report
//   states (key, mouse, pad) end the walk, whether or not a report is
//   emitted in each.
//   Reset clears held flags, report registers and dirty marks; the entry
//   memories hold garbage until written and are only acted on for held entries.
// ----------------------------------------------------------------------------
module button_to_hid_report_mapper_core #(
  parameter int NODES     = 4,
  parameter int BUTTONS   = 8,
  parameter int KEY_SLOTS = 6,
  parameter int ACTIONS   = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  bthid_pkg::in_item_t   in_i,
  output logic                  out_valid_o,
  output bthid_pkg::out_item_t  out_o
);
  import bthid_pkg::*;

  localparam int ENTRIES = NODES * BUTTONS;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AW = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
  localparam int MW = EW + AW;
  localparam int KS = (KEY_SLOTS < 6) ? KEY_SLOTS : 6;

  // Entry memories: actions, repeat delay, next due time.
  logic [18:0] act_mem [ENTRIES*(2**AW)];
  logic [15:0] rep_mem [ENTRIES];
  logic [31:0] due_mem [ENTRIES];
  logic [ENTRIES-1:0] held_q, held_d;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  logic [EW-1:0] ent_q, ent_d;
  logic [AW-1:0] act_q, act_d;

  logic [7:0]  key_q [KEY_SLOTS];
  logic [7:0]  key_d [KEY_SLOTS];
  logic [7:0]  mod_q, mod_d, mbtn_q, mbtn_d;
  logic [7:0]  mot_q [3];
  logic [7:0]  mot_d [3];
  logic [7:0]  acc_q [3];
  logic [7:0]  acc_d [3];
  logic        mdirty_q, mdirty_d;
  logic [31:0] pad_q, pad_d;
  logic [2:0]  dirty_q, dirty_d;

  // Memory read/write control
  logic          act_we, ent_we;
  logic [MW-1:0] act_waddr, act_raddr;
  logic [18:0]   act_wdata, act_rd;
  logic [15:0]   rep_wdata, rep_rd;
  logic [31:0]   due_wdata, due_rd;
  logic [EW-1:0] ent_raddr;

  always_ff @(posedge clk_i) begin
    if (act_we) act_mem[act_waddr] <= act_wdata;
    act_rd <= act_mem[act_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      rep_mem[ent_q] <= rep_wdata;
      due_mem[ent_q] <= due_wdata;
    end
    rep_rd <= rep_mem[ent_raddr];
    due_rd <= due_mem[ent_raddr];
  end

  function automatic logic [18:0] pick_action(in_item_t it, logic [AW-1:0] a);
    logic [18:0] r;
    r = it.action_a;
    case (a)
      AW'(0): r = it.action_a;
      AW'(1): r = it.action_b;
      AW'(2): r = it.action_c;
      default: r = it.action_d;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
    logic signed [8:0] s;
    s = $signed({a[7], a}) + $signed({b[7], b});
    if (s > 9'sd127) return 8'd127;
    if (s < -9'sd127) return 8'h81;
    return s[7:0];
  endfunction

  logic [18:0] cur_act;
  logic [2:0]  a_type;
  logic [7:0]  a_code, a_mod;
  logic        last_act;
  logic        last_rd;
  logic        found;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    cur_act = (state_q == ST_PRESS_ACT) ? pick_action(item_q, act_q) : act_rd;
    a_type  = cur_act[18:16];
    a_code  = cur_act[15:8];
    a_mod   = cur_act[7:0];
    last_act = (act_q == AW'(ACTIONS-1));
    // Memory-fed actions run one index behind the read counter.
    last_rd  = (act_q == AW'(ACTIONS));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) begin
        case (cmd_e'(in_i.cmd))
          CMD_PRESS, CMD_RELEASE: begin
            if (32'(in_i.node) < NODES && 32'(in_i.button) < BUTTONS) begin
              if (in_i.cmd == CMD_PRESS) state_d = ST_PRESS_ACT;
              else if (held_q[EW'(32'(in_i.node) * BUTTONS + 32'(in_i.button))])
                state_d = ST_REL_RD;
            end
          end
          CMD_TICK: state_d = ST_TICK_RD;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_PRESS_ACT: if (last_act) state_d = ST_IDLE;
      ST_REL_RD:    state_d = ST_REL_ACT;
      ST_REL_ACT:   if (last_rd) state_d = ST_IDLE;
      ST_TICK_RD:   state_d = ST_TICK_CHK;
      ST_TICK_CHK: begin
        if (held_q[ent_q] && rep_rd != 16'd0 && item_q.now_ms >= due_rd)
          state_d = ST_TICK_ACT;
        else if (ent_q == EW'(ENTRIES-1)) state_d = ST_EMIT_KEY;
        else state_d = ST_TICK_RD;
      end
      ST_TICK_ACT: if (last_rd) state_d = ST_TICK_SUM;
      ST_TICK_SUM:
        state_d = (ent_q == EW'(ENTRIES-1)) ? ST_EMIT_KEY : ST_TICK_RD;
      ST_EMIT_KEY:   state_d = ST_EMIT_MOUSE;
      ST_EMIT_MOUSE: state_d = ST_EMIT_PAD;
      ST_EMIT_PAD:   state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_d = item_q; ent_d = ent_q; act_d = act_q; held_d = held_q;
    key_d = key_q; mod_d = mod_q; mbtn_d = mbtn_q; mot_d = mot_q;
    acc_d = acc_q; mdirty_d = mdirty_q; pad_d = pad_q; dirty_d = dirty_q;
    act_we = 1'b0; act_waddr = {ent_q, act_q}; act_wdata = cur_act;
    ent_we = 1'b0; rep_wdata = item_q.repeat_delay;
    due_wdata = item_q.now_ms + 32'(item_q.first_delay);
    act_raddr = {ent_q, act_q}; ent_raddr = ent_q;
    found = 1'b0;
    out_valid_o = 1'b0;
    out_o = '0;
    case (state_q)
      ST_IDLE: begin
        act_d = '0;
        if (start) begin
          item_d = in_i;
          ent_d = EW'(32'(in_i.node) * BUTTONS + 32'(in_i.button));
          if (in_i.cmd == CMD_UNMOUNT) begin
            for (int i = 0; i < KEY_SLOTS; i++) key_d[i] = '0;
            mod_d = '0; mbtn_d = '0; pad_d = '0;
          end
          if (in_i.cmd == CMD_TICK) ent_d = '0;
        end
      end
      ST_PRESS_ACT: begin
        act_we = 1'b1;
        ent_we = (act_q == '0);
        held_d[ent_q] = 1'b1;
        act_d = act_q + AW'(1);
        case (a_type)
          T_KEY: begin
            for (int i = 0; i < KEY_SLOTS; i++)
              if (!found && key_d[i] == 8'd0) begin
                key_d[i] = a_code; found = 1'b1;
              end
            mod_d = mod_q | a_mod; dirty_d[0] = 1'b1;
          end
          T_MOUSE: begin
            if (a_code < 8'd8) mbtn_d[a_code[2:0]] = 1'b1;
            dirty_d[1] = 1'b1;
          end
          T_AXIS: begin
            if (a_code < 8'd3) mot_d[a_code[1:0]] = mot_q[a_code[1:0]] + a_mod;
            dirty_d[1] = 1'b1;
          end
          T_PAD: begin
            if (a_code < 8'd32) pad_d[a_code[4:0]] = 1'b1;
            dirty_d[2] = 1'b1;
          end
          default: ;
        endcase
      end
      ST_REL_RD: begin
        held_d[ent_q] = 1'b0;
        act_d = act_q + AW'(1);
        act_raddr = {ent_q, act_q};
      end
      ST_REL_ACT: begin
        act_d = act_q + AW'(1);
        act_raddr = {ent_q, act_q};
        if (last_rd) begin
          ent_we = 1'b1; rep_wdata = rep_rd; due_wdata = '0;
        end
        case (a_type)
          T_KEY: begin
            for (int i = 0; i < KEY_SLOTS; i++)
              if (key_q[i] == a_code) key_d[i] = 8'd0;
            mod_d = mod_q & ~a_mod; dirty_d[0] = 1'b1;
          end
          T_MOUSE: begin
            if (a_code < 8'd8) mbtn_d[a_code[2:0]] = 1'b0;
            dirty_d[1] = 1'b1;
          end
          T_PAD: begin
            if (a_code < 8'd32) pad_d[a_code[4:0]] = 1'b0;
            dirty_d[2] = 1'b1;
          end
          default: ;
        endcase
      end
      ST_TICK_RD: begin
        act_d = '0;
        for (int k = 0; k < 3; k++) acc_d[k] = '0;
        mdirty_d = 1'b0;
      end
      ST_TICK_CHK: begin
        act_raddr = {ent_q, AW'(0)};
        act_d = AW'(1);
        if (!(held_q[ent_q] && rep_rd != 16'd0 && item_q.now_ms >= due_rd))
          ent_d = ent_q + EW'(1);
      end
      ST_TICK_ACT: begin
        act_d = act_q + AW'(1);
        act_raddr = {ent_q, act_q};
        case (a_type)
          T_KEY: dirty_d[0] = 1'b1;
          T_MOUSE: mdirty_d = 1'b1;
          T_AXIS: begin
            if (a_code < 8'd3) acc_d[a_code[1:0]] = acc_q[a_code[1:0]] + a_mod;
            mdirty_d = 1'b1;
          end
          T_PAD: dirty_d[2] = 1'b1;
          default: ;
        endcase
      end
      ST_TICK_SUM: begin
        if (mdirty_q) begin
          for (int k = 0; k < 3; k++) mot_d[k] = sat_add(mot_q[k], acc_q[k]);
          dirty_d[1] = 1'b1;
        end
        ent_we = 1'b1; rep_wdata = rep_rd;
        due_wdata = item_q.now_ms + 32'(rep_rd);
        ent_d = ent_q + EW'(1);
      end
      ST_EMIT_KEY: begin
        if (item_q.host_ready && dirty_q[0]) begin
          out_valid_o = 1'b1;
          out_o.report_kind = KIND_KEY;
          for (int i = 0; i < KS; i++) out_o.key_slots[8*i +: 8] = key_q[i];
          out_o.modifier_bits = mod_q;
          out_o.last_report = (dirty_q[2:1] == 2'b00);
        end
      end
      ST_EMIT_MOUSE: begin
        if (item_q.host_ready && dirty_q[1]) begin
          out_valid_o = 1'b1;
          out_o.report_kind = KIND_MOUSE;
          out_o.mouse_button_bits = mbtn_q;
          out_o.delta_x = mot_q[0];
          out_o.delta_y = mot_q[1];
          out_o.delta_wheel = mot_q[2];
          out_o.last_report = !dirty_q[2];
          for (int k = 0; k < 3; k++) mot_d[k] = '0;
        end
      end
      ST_EMIT_PAD: begin
        if (item_q.host_ready) begin
          if (dirty_q[2]) begin
            out_valid_o = 1'b1;
            out_o.report_kind = KIND_PAD;
            out_o.pad_button_bits = pad_q;
            out_o.last_report = 1'b1;
          end
          dirty_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) key_q[i] <= '0;
      mod_q <= '0; mbtn_q <= '0; pad_q <= '0; dirty_q <= '0;
      for (int k = 0; k < 3; k++) begin
        mot_q[k] <= '0; acc_q[k] <= '0;
      end
      mdirty_q <= 1'b0; ent_q <= '0; act_q <= '0;
    end else begin
      state_q <= state_d; held_q <= held_d; key_q <= key_d;
      mod_q <= mod_d; mbtn_q <= mbtn_d; pad_q <= pad_d; dirty_q <= dirty_d;
      mot_q <= mot_d; acc_q <= acc_d; mdirty_q <= mdirty_d;
      ent_q <= ent_d; act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

/* design/bthid_checker.sv */
// ----------------------------------------------------------------------------
// bthid_checker
// Port-level checks for the button to HID report mapper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bthid_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid_o,
  input bthid_pkg::out_item_t out_o
);
  import bthid_pkg::*;

  `ASSERT_IMPL(a_kind_ok, clk_i, rst_ni, out_valid_o, out_o.report_kind != 2'd3)
  `ASSERT_IMPL(a_out_busy, clk_i, rst_ni, out_valid_o, busy)
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy && out_valid_o, 1'b0)
  `ASSERT_NEXT(a_last_ends, clk_i, rst_ni, out_valid_o && out_o.last_report, !out_valid_o)

endmodule

bind button_to_hid_report_mapper_core bthid_checker u_bthid_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .out_valid_o(out_valid_o), .out_o(out_o)
);

/* dv/tb_button_to_hid_report_mapper_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_to_hid_report_mapper_core
// Self-checking bench for the button to HID report mapper. Drives press,
// release, tick and unmount transactions and checks every emitted report
// against a cycle-free behavioral predictor of the report state.
// ----------------------------------------------------------------------------
module tb_button_to_hid_report_mapper_core;
  import bthid_pkg::*;

  localparam int NODES     = 4;
  localparam int BUTTONS   = 8;
  localparam int KEY_SLOTS = 6;
  localparam int ACTIONS   = 4;
  localparam int ENTRIES   = NODES * BUTTONS;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_i = '0;
  logic       out_valid_o;
  out_item_t  out_o;

  button_to_hid_report_mapper_core #(
    .NODES(NODES), .BUTTONS(BUTTONS), .KEY_SLOTS(KEY_SLOTS), .ACTIONS(ACTIONS)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_o(out_o)
  );

  always #1 clk_i = ~clk_i;

  // Predicted block state.
  logic        held_q   [ENTRIES];
  logic [18:0] binding_q[ENTRIES][ACTIONS];
  logic [15:0] period_q [ENTRIES];
  logic [31:0] due_q    [ENTRIES];
  logic [7:0]  keys_q   [KEY_SLOTS];
  logic [7:0]  mods_q, mbtn_q;
  logic [7:0]  motion_q [3];
  logic [31:0] pad_q;
  logic [2:0]  dirty_q;

  out_item_t report_q[$];
  int        errors = 0;
  int        quiet  = 0;   // nonzero: no idle gaps on the send side
  logic [31:0] clock_ms = 32'd0;

  function automatic logic [7:0] bit8(logic [7:0] code);
    return (code < 8) ? (8'd1 << code) : 8'd0;
  endfunction

  function automatic logic [31:0] bit32(logic [7:0] code);
    return (code < 32) ? (32'd1 << code) : 32'd0;
  endfunction

  task automatic press_action(logic [18:0] act);
    logic [2:0] ty;
    logic [7:0] code, md;
    ty = act[18:16]; code = act[15:8]; md = act[7:0];
    if (ty == T_KEY) begin
      // Take the first empty slot; drop the code if none is left.
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (keys_q[i] == 8'd0) begin
          keys_q[i] = code;
          break;
        end
      end
      mods_q |= md;
      dirty_q[0] = 1'b1;
    end else if (ty == T_MOUSE) begin
      mbtn_q |= bit8(code);
      dirty_q[1] = 1'b1;
    end else if (ty == T_AXIS) begin
      if (code < 3) motion_q[code] = motion_q[code] + md;
      dirty_q[1] = 1'b1;
    end else if (ty == T_PAD) begin
      pad_q |= bit32(code);
      dirty_q[2] = 1'b1;
    end
  endtask

  task automatic release_action(logic [18:0] act);
    logic [2:0] ty;
    logic [7:0] code, md;
    ty = act[18:16]; code = act[15:8]; md = act[7:0];
    if (ty == T_KEY) begin
      for (int i = 0; i < KEY_SLOTS; i++) if (keys_q[i] == code) keys_q[i] = 8'd0;
      mods_q &= ~md;
      dirty_q[0] = 1'b1;
    end else if (ty == T_MOUSE) begin
      mbtn_q &= ~bit8(code);
      dirty_q[1] = 1'b1;
    end else if (ty == T_PAD) begin
      pad_q &= ~bit32(code);
      dirty_q[2] = 1'b1;
    end
  endtask

  task automatic fire_repeat(int e, logic [31:0] now);
    logic [7:0] acc[3];
    logic       mdirty;
    int         s;
    acc = '{8'd0, 8'd0, 8'd0};
    mdirty = 1'b0;
    for (int a = 0; a < ACTIONS; a++) begin
      case (binding_q[e][a][18:16])
        T_KEY:   dirty_q[0] = 1'b1;
        T_MOUSE: mdirty = 1'b1;
        T_AXIS: begin
          if (binding_q[e][a][15:8] < 3)
            acc[binding_q[e][a][15:8]] += binding_q[e][a][7:0];
          mdirty = 1'b1;
        end
        T_PAD:   dirty_q[2] = 1'b1;
        default: ;
      endcase
    end
    if (mdirty) begin
      // Saturate the sum to +-127.
      for (int k = 0; k < 3; k++) begin
        s = int'($signed(motion_q[k])) + int'($signed(acc[k]));
        if (s > 127) s = 127;
        if (s < -127) s = -127;
        motion_q[k] = s[7:0];
      end
      dirty_q[1] = 1'b1;
    end
    due_q[e] = now + 32'(period_q[e]);
  endtask

  // Advance the predictor by one accepted transaction.
  task automatic predict_reports(in_item_t it);
    int        e, n;
    out_item_t r;
    out_item_t made[$];
    e = int'(it.node) * BUTTONS + int'(it.button);
    case (cmd_e'(it.cmd))
      CMD_PRESS: begin
        held_q[e] = 1'b1;
        period_q[e] = it.repeat_delay;
        due_q[e] = it.now_ms + 32'(it.first_delay);
        binding_q[e][0] = it.action_a;
        binding_q[e][1] = it.action_b;
        binding_q[e][2] = it.action_c;
        binding_q[e][3] = it.action_d;
        for (int a = 0; a < ACTIONS; a++) press_action(binding_q[e][a]);
      end
      CMD_RELEASE: begin
        if (held_q[e]) begin
          held_q[e] = 1'b0;
          due_q[e] = 32'd0;
          for (int a = 0; a < ACTIONS; a++) release_action(binding_q[e][a]);
        end
      end
      CMD_UNMOUNT: begin
        for (int i = 0; i < KEY_SLOTS; i++) keys_q[i] = 8'd0;
        mods_q = 8'd0;
        mbtn_q = 8'd0;
        pad_q = 32'd0;
      end
      default: begin
        for (int x = 0; x < ENTRIES; x++)
          if (held_q[x] && period_q[x] != 16'd0 && it.now_ms >= due_q[x])
            fire_repeat(x, it.now_ms);
        if (it.host_ready) begin
          if (dirty_q[0]) begin
            r = '0;
            r.report_kind = KIND_KEY;
            for (int i = 0; i < KEY_SLOTS; i++) r.key_slots[8*i +: 8] = keys_q[i];
            r.modifier_bits = mods_q;
            made.push_back(r);
          end
          if (dirty_q[1]) begin
            r = '0;
            r.report_kind = KIND_MOUSE;
            r.mouse_button_bits = mbtn_q;
            r.delta_x = motion_q[0];
            r.delta_y = motion_q[1];
            r.delta_wheel = motion_q[2];
            motion_q = '{8'd0, 8'd0, 8'd0};
            made.push_back(r);
          end
          if (dirty_q[2]) begin
            r = '0;
            r.report_kind = KIND_PAD;
            r.pad_button_bits = pad_q;
            made.push_back(r);
          end
          dirty_q = 3'd0;
          n = made.size();
          if (n > 0) made[n-1].last_report = 1'b1;
          foreach (made[i]) report_q.push_back(made[i]);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Check each report against the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t w;
    if (rst_ni && out_valid_o) begin
      if (report_q.size() == 0) begin
        report_mismatch("unexpected report kind", 64'(out_o.report_kind), 64'd0);
      end else begin
        w = report_q.pop_front();
        if (out_o.report_kind !== w.report_kind)
          report_mismatch("report_kind", 64'(out_o.report_kind), 64'(w.report_kind));
        if (out_o.key_slots !== w.key_slots)
          report_mismatch("key_slots", 64'(out_o.key_slots), 64'(w.key_slots));
        if (out_o.modifier_bits !== w.modifier_bits)
          report_mismatch("modifier_bits", 64'(out_o.modifier_bits), 64'(w.modifier_bits));
        if (out_o.mouse_button_bits !== w.mouse_button_bits)
          report_mismatch("mouse_button_bits", 64'(out_o.mouse_button_bits),
                          64'(w.mouse_button_bits));
        if (out_o.delta_x !== w.delta_x)
          report_mismatch("delta_x", 64'(out_o.delta_x), 64'(w.delta_x));
        if (out_o.delta_y !== w.delta_y)
          report_mismatch("delta_y", 64'(out_o.delta_y), 64'(w.delta_y));
        if (out_o.delta_wheel !== w.delta_wheel)
          report_mismatch("delta_wheel", 64'(out_o.delta_wheel), 64'(w.delta_wheel));
        if (out_o.pad_button_bits !== w.pad_button_bits)
          report_mismatch("pad_button_bits", 64'(out_o.pad_button_bits),
                          64'(w.pad_button_bits));
        if (out_o.last_report !== w.last_report)
          report_mismatch("last_report", 64'(out_o.last_report), 64'(w.last_report));
      end
    end
  end

  // Send one transaction: optional idle gap, then hold start until accepted.
  // Start stays high after the accepting edge; the next gap or drain drops it.
  task automatic send_txn(in_item_t it);
    while (quiet == 0 && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    in_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_reports(it);
  endtask

  function automatic logic [18:0] rand_action();
    logic [18:0] act;
    act = 19'($urandom);
    case ($urandom_range(9))
      0, 1, 2: act[18:16] = T_KEY;
      3:       act[18:16] = T_MOUSE;
      4, 5:    act[18:16] = T_AXIS;
      6:       act[18:16] = T_PAD;
      default: ;
    endcase
    // Keep codes mostly in the meaningful range.
    if ($urandom_range(3) != 0) act[15:8] = 8'($urandom_range(40));
    return act;
  endfunction

  function automatic in_item_t make_txn(cmd_e c, int node, int btn);
    in_item_t it;
    it = '0;
    it.cmd = c;
    it.node = 2'(node);
    it.button = 3'(btn);
    it.action_a = rand_action();
    it.action_b = rand_action();
    it.action_c = rand_action();
    it.action_d = rand_action();
    it.first_delay = 16'($urandom_range(30));
    it.repeat_delay = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 20));
    it.now_ms = clock_ms;
    it.host_ready = ($urandom_range(4) != 0);
    return it;
  endfunction

  task automatic tick(logic ready);
    in_item_t it;
    it = make_txn(CMD_TICK, $urandom_range(3), $urandom_range(7));
    it.host_ready = ready;
    send_txn(it);
  endtask

  // Drop start, hold until every predicted report has come out, then let the
  // tick settle.
  task automatic drain();
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic test_directed();
    in_item_t it;
    // Extremes: all ones, key slots overflow, wide codes, axis wrap.
    it = make_txn(CMD_PRESS, 0, 0);
    it.action_a = {T_KEY, 8'hFF, 8'hFF};
    it.action_b = {T_MOUSE, 8'd7, 8'h00};
    it.action_c = {T_AXIS, 8'd0, 8'h7F};
    it.action_d = {T_PAD, 8'd31, 8'h00};
    it.first_delay = 16'hFFFF;
    it.repeat_delay = 16'hFFFF;
    send_txn(it);
    tick(1'b1);
    for (int b = 1; b < 8; b++) begin   // more keys than slots
      it = make_txn(CMD_PRESS, 1, b);
      it.action_a = {T_KEY, 8'(b + 4), 8'(1 << (b % 8))};
      it.action_b = {T_MOUSE, 8'd8, 8'h00};
      it.action_c = {T_PAD, 8'd32, 8'h00};
      it.action_d = {3'd7, 8'hFF, 8'hFF};
      send_txn(it);
    end
    it = make_txn(CMD_PRESS, 3, 7);
    it.action_a = {T_AXIS, 8'd1, 8'h80};
    it.action_b = {T_AXIS, 8'd2, 8'h81};
    it.action_c = {T_AXIS, 8'd5, 8'h01};
    it.action_d = {3'd5, 8'h00, 8'h00};
    it.first_delay = 16'd0;
    it.repeat_delay = 16'd1;
    send_txn(it);
    tick(1'b0);                 // host not ready: marks stay
    tick(1'b1);
    it = make_txn(CMD_RELEASE, 2, 2);  // release of an idle entry
    send_txn(it);
    it = make_txn(CMD_RELEASE, 1, 3);
    send_txn(it);
    it = make_txn(CMD_PRESS, 1, 4);    // press of a held entry
    send_txn(it);
    clock_ms = 32'hFFFF_FFF0;          // due time can wrap
    it = make_txn(CMD_PRESS, 2, 0);
    it.action_a = {T_AXIS, 8'd0, 8'h81};
    it.repeat_delay = 16'd100;
    send_txn(it);
    tick(1'b1);
    clock_ms = 32'hFFFF_FFFF;
    tick(1'b1);
    send_txn(make_txn(CMD_UNMOUNT, 0, 0));
    tick(1'b1);
    clock_ms = 32'd100;
    drain();
  endtask

  task automatic test_random(int count);
    int c;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 2);  // stretch without gaps
      clock_ms += 32'($urandom_range(6));
      c = $urandom_range(19);
      if (c < 8)       send_txn(make_txn(CMD_PRESS, $urandom_range(3), $urandom_range(7)));
      else if (c < 14) send_txn(make_txn(CMD_RELEASE, $urandom_range(3), $urandom_range(7)));
      else if (c < 19) tick($urandom_range(4) != 0);
      else             send_txn(make_txn(CMD_UNMOUNT, 0, 0));
    end
    quiet = 0;
    tick(1'b1);
    drain();
  endtask

  initial begin
    for (int e = 0; e < ENTRIES; e++) begin
      held_q[e] = 1'b0;
      period_q[e] = 16'd0;
      due_q[e] = 32'd0;
      for (int a = 0; a < ACTIONS; a++) binding_q[e][a] = '0;
    end
    for (int i = 0; i < KEY_SLOTS; i++) keys_q[i] = 8'd0;
    mods_q = 8'd0; mbtn_q = 8'd0; pad_q = 32'd0; dirty_q = 3'd0;
    motion_q = '{8'd0, 8'd0, 8'd0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: fails the run if about 470 items have not finished by then.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/bthid_pkg.sv
design/button_to_hid_report_mapper_core.sv
design/bthid_checker.sv
dv/tb_button_to_hid_report_mapper_core.sv
